[hw/rtl/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants for the bisection square root
// Holds default widths, the tolerance register format, the controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int                  TOL_WIDTH = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CMP,
        ST_DONE
    } bsr_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture a new word and its first guess
        logic mul;       // register the partial products of the guess
        logic sum;       // register the full square
        logic step;      // move one bound and take a new midpoint
        logic out_load;  // copy the final guess into the result register
    } bsr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic finish;    // exact hit, or bracket flat, inverted or within tolerance
    } bsr_stat_t;

endpackage

[hw/rtl/bsr_ctrl.sv]
// ----------------------------------------------------------------------------
// bsr_ctrl: sequencer for the bisection square root
// Walks each guess through multiply, sum and compare, and manages the
// result register handshake.
// ----------------------------------------------------------------------------
module bsr_ctrl
    import bsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  bsr_stat_t stat,
    output bsr_cmd_t  cmd
);

    bsr_state_t state_reg;
    bsr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // Result register may be refilled when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.finish)
                begin
                    if (slot_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // hold the finished guess until the result register frees up
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/bsr_dp.sv]
// ----------------------------------------------------------------------------
// bsr_dp: datapath for the bisection square root
// Holds the bracket, the guess and its square (built from three half-width
// products), the tolerance register and the result register.
// ----------------------------------------------------------------------------
module bsr_dp
    import bsr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [TOL_WIDTH-1:0]  cfg_wr_data,
    input  logic [DATA_WIDTH-1:0] radicand,
    input  logic [DATA_WIDTH-1:0] lower_bound,
    input  logic [DATA_WIDTH-1:0] upper_bound,
    input  bsr_cmd_t              cmd,
    output bsr_stat_t             stat,
    output logic [DATA_WIDTH-1:0] root,
    output logic                  exact
);

    localparam int HALF  = (DATA_WIDTH + 1) / 2;
    localparam int HIGH  = DATA_WIDTH - HALF;
    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int CMP_W = 2 * DATA_WIDTH + FRAC_BITS;
    localparam int WID_W = (DATA_WIDTH > TOL_WIDTH) ? DATA_WIDTH : TOL_WIDTH;

    logic [TOL_WIDTH-1:0]    tol_reg;
    logic [DATA_WIDTH-1:0]   x_reg;
    logic [DATA_WIDTH-1:0]   lo_reg;
    logic [DATA_WIDTH-1:0]   hi_reg;
    logic [DATA_WIDTH-1:0]   guess_reg;
    logic [2*HIGH-1:0]       hh_reg;
    logic [HIGH+HALF-1:0]    hl_reg;
    logic [2*HALF-1:0]       ll_reg;
    logic                    cont_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DATA_WIDTH-1:0]   root_reg;
    logic                    exact_reg;

    logic [HIGH-1:0]         g_hi;
    logic [HALF-1:0]         g_lo;
    logic [2*HIGH-1:0]       hh_next;
    logic [HIGH+HALF-1:0]    hl_next;
    logic [2*HALF-1:0]       ll_next;
    logic [SQ_W-1:0]         sq_next;
    logic [TOL_WIDTH-1:0]    tol_eff;
    logic [DATA_WIDTH-1:0]   width;
    logic                    cont_next;
    logic [CMP_W-1:0]        target;
    logic [CMP_W-1:0]        sq_ext;
    logic                    sq_gt;
    logic                    sq_eq;
    logic [DATA_WIDTH-1:0]   lo_step;
    logic [DATA_WIDTH-1:0]   hi_step;

    // Floor midpoint, formed one bit wider so it never wraps
    function automatic logic [DATA_WIDTH-1:0] mid_of(
        input logic [DATA_WIDTH-1:0] a,
        input logic [DATA_WIDTH-1:0] b
    );
        logic [DATA_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_WIDTH:1];
    endfunction

    assign g_hi = guess_reg[DATA_WIDTH-1:HALF];
    assign g_lo = guess_reg[HALF-1:0];

    assign hh_next = {{HIGH{1'b0}}, g_hi} * {{HIGH{1'b0}}, g_hi};
    assign hl_next = {{HALF{1'b0}}, g_hi} * {{HIGH{1'b0}}, g_lo};
    assign ll_next = {{HALF{1'b0}}, g_lo} * {{HALF{1'b0}}, g_lo};

    // Cross term appears twice, hence the extra shift
    assign sq_next = (SQ_W'(hh_reg) << (2 * HALF))
                   + (SQ_W'(hl_reg) << (HALF + 1))
                   + SQ_W'(ll_reg);

    // Zero tolerance acts as one so the bracket always shrinks
    assign tol_eff   = (tol_reg == '0) ? TOL_WIDTH'(1) : tol_reg;
    assign width     = hi_reg - lo_reg;
    assign cont_next = (hi_reg > lo_reg) && (WID_W'(width) > WID_W'(tol_eff));

    assign target = CMP_W'(x_reg) << FRAC_BITS;
    assign sq_ext = CMP_W'(sq_reg);
    assign sq_gt  = (sq_ext > target);
    assign sq_eq  = (sq_ext == target);

    assign stat.finish = sq_eq || !cont_reg;

    assign lo_step = sq_gt ? lo_reg : guess_reg;
    assign hi_step = sq_gt ? guess_reg : hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= radicand;
            lo_reg    <= lower_bound;
            hi_reg    <= upper_bound;
            guess_reg <= mid_of(lower_bound, upper_bound);
        end
        else if (cmd.step)
        begin
            lo_reg    <= lo_step;
            hi_reg    <= hi_step;
            guess_reg <= mid_of(lo_step, hi_step);
        end

        if (cmd.mul)
        begin
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            cont_reg <= cont_next;
        end

        if (cmd.sum)
        begin
            sq_reg <= sq_next;
        end

        if (cmd.out_load)
        begin
            root_reg  <= guess_reg;
            exact_reg <= sq_eq;
        end
    end

    assign root  = root_reg;
    assign exact = exact_reg;

endmodule

[hw/rtl/bisection_square_root.sv]
// Each accepted word runs through n bisection steps (at most about DATA_WIDTH);
// each step passes through a multiply, a sum and a compare state around the
// shared squaring datapath. A new word is accepted only in the idle state, once
// the previous result has been loaded into the result register.
// Reset: asynchronous, active low; clears the sequencer and result valid and
// sets the tolerance register to 1.
// ----------------------------------------------------------------------------
// bisection_square_root: fixed-point square root by bisection
// Each input word carries a radicand and a bracket. The guess starts at the
// floor midpoint; while its square differs from the scaled radicand and the
// bracket is wider than the tolerance, one bound moves to the guess.
// ----------------------------------------------------------------------------
module bisection_square_root
    import bsr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // tolerance register write port
    input  logic                  cfg_wr_en,
    input  logic [TOL_WIDTH-1:0]  cfg_wr_data,

    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] radicand,
    input  logic [DATA_WIDTH-1:0] lower_bound,
    input  logic [DATA_WIDTH-1:0] upper_bound,

    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] root,
    output logic                  exact
);

    bsr_cmd_t  cmd;
    bsr_stat_t stat;

    // Sequencer: one state per phase of a bisection step, plus a hold state
    // for when the result register is still occupied by the previous word.
    bsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: bracket, guess, split-multiplier square, compare, and the
    // result register that parts the two channels.
    bsr_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .radicand    (radicand),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .cmd         (cmd),
        .stat        (stat),
        .root        (root),
        .exact       (exact)
    );

`ifndef SYNTHESIS
    // An accepted word keeps the input side stalled on the next cycle
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a word");

    // Loading the result register always presents a valid word next cycle
    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded but output not valid");

    // Never overwrite a result that is still stalled on the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && out_valid && out_stall))
        else $error("result register overwritten while stalled");
`endif

endmodule

[dv/bisection_square_root_tb.sv]
// ----------------------------------------------------------------------------
// bisection_square_root_tb: self-checking bench for the bisection square root
// Drives radicand/bracket words with random gaps, stalls the result side at
// random, predicts every root and exact flag at the block's own widths, and
// compares each result in order. The tolerance register moves through
// zero, one, its maximum and a random value between groups of words.
// ----------------------------------------------------------------------------
module bisection_square_root_tb;
    import bsr_pkg::*;

    localparam int W           = DATA_WIDTH_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOW_LIMIT  = 10;

    typedef logic [W-1:0]         word_t;
    typedef logic [2*W-1:0]       square_t;
    typedef logic [TOL_WIDTH-1:0] tol_t;

    typedef struct {
        word_t x;
        word_t lo;
        word_t hi;
        word_t root;
        logic  exact;
    } root_expect_t;

    // Holds the tolerance copy and the queue of predicted roots.
    class root_scoreboard;
        tol_t         tolerance_reg = TOL_RESET;
        root_expect_t pending_roots[$];
        int unsigned  words_noted   = 0;
        int unsigned  roots_checked = 0;
        int unsigned  exact_roots   = 0;
        int unsigned  flat_brackets = 0;
        int unsigned  errors        = 0;

        function automatic root_expect_t bisect_root(word_t x, word_t lo, word_t hi);
            root_expect_t e;
            tol_t         tol;
            logic [W:0]   sum;
            word_t        guess;
            square_t      target;
            square_t      square;
            tol = (tolerance_reg == '0) ? tol_t'(1) : tolerance_reg;
            target = square_t'(x) << FRAC;
            e.x  = x;
            e.lo = lo;
            e.hi = hi;
            // midpoint at one extra bit so that it never wraps
            sum = {1'b0, lo} + {1'b0, hi};
            guess = sum[W:1];
            square = square_t'(guess) * square_t'(guess);
            while (square != target && hi > lo && (hi - lo) > word_t'(tol))
            begin
                if (square > target)
                    hi = guess;
                else
                    lo = guess;
                sum = {1'b0, lo} + {1'b0, hi};
                guess = sum[W:1];
                square = square_t'(guess) * square_t'(guess);
            end
            e.root  = guess;
            e.exact = (square == target);
            return e;
        endfunction

        function void note_word(word_t x, word_t lo, word_t hi);
            pending_roots.push_back(bisect_root(x, lo, hi));
            words_noted++;
            if (hi <= lo)
                flat_brackets++;
        endfunction

        function void check_result(word_t root, logic exact);
            root_expect_t e;
            if (pending_roots.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("[%0t] unexpected result: root %h exact %0d", $realtime,
                             root, exact);
                return;
            end
            e = pending_roots.pop_front();
            roots_checked++;
            if (exact)
                exact_roots++;
            if (root !== e.root || exact !== e.exact)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                begin
                    $display("[%0t] mismatch x=%h lo=%h hi=%h tol=%0d:",
                             $realtime, e.x, e.lo, e.hi, tolerance_reg);
                    $display("    expected root %h exact %0d, got root %h exact %0d",
                             e.root, e.exact, root, exact);
                end
            end
        endfunction

        function int unsigned pending();
            return pending_roots.size();
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    tol_t  cfg_wr_data = '0;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    word_t radicand    = '0;
    word_t lower_bound = '0;
    word_t upper_bound = '0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    word_t root;
    logic  exact;

    root_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    int unsigned    quiet_words = 0;

    bisection_square_root #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (FRAC)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .radicand    (radicand),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root        (root),
        .exact       (exact)
    );

    always #4 clk = ~clk;

    // Abort a hung run; the bound is several times the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d roots still owed", cycle_count,
                     sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample results at the rising edge, where the handshake completes.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(root, exact);
    end

    // Mostly short gaps, a few long ones; never an empty gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Idle cycles before the next input word; none during quiet stretches.
    function automatic int unsigned next_input_gap();
        if (quiet_words > 0)
        begin
            quiet_words--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            quiet_words = 40;
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : pick_gap();
    endfunction

    // Result side: random stall bursts, now and then a long stretch of none.
    initial
    begin : stall_gen
        int unsigned len;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                len = $urandom_range(100, 300);
                repeat (len) @(negedge clk) out_stall <= 1'b0;
            end
            else
            begin
                len = $urandom_range(0, 6);
                repeat (len) @(negedge clk) out_stall <= 1'b0;
                len = pick_gap();
                repeat (len) @(negedge clk) out_stall <= 1'b1;
            end
        end
    end

    // Present one word at a falling edge and hold it until accepted.
    task automatic push_word(input word_t x, input word_t lo, input word_t hi);
        int unsigned gap;
        gap = next_input_gap();
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        radicand    <= x;
        lower_bound <= lo;
        upper_bound <= hi;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(x, lo, hi);
    endtask

    // Drop valid and let every owed root arrive before touching the register.
    task automatic drain_words();
        @(negedge clk) in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_tolerance(input tol_t value);
        drain_words();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.tolerance_reg = value;
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    // Random word: mostly brackets around the true root or around an exact
    // square, the rest inverted/flat brackets and raw noise.
    task automatic make_random_word(output word_t x, output word_t lo, output word_t hi);
        int unsigned kind;
        int unsigned k;
        longint      r;
        longint      below;
        longint      above;
        longint      top;
        kind = $urandom_range(0, 99);
        top  = (longint'(1) << W) - 1;
        if (kind < 50)
        begin
            x     = $urandom() >> $urandom_range(0, 31);
            r     = longint'($floor($sqrt(real'(x) * real'(longint'(1) << FRAC))));
            below = $urandom() >> $urandom_range(0, 31);
            above = $urandom() >> $urandom_range(0, 31);
            lo    = (r > below) ? word_t'(r - below) : '0;
            hi    = (r + above > top) ? word_t'(top) : word_t'(r + above);
        end
        else if (kind < 65)
        begin
            // guess lands on k<<8 after a few halvings of [0, (k<<8)<<m]
            k  = $urandom_range(0, 65535);
            x  = word_t'(k) * word_t'(k);
            lo = '0;
            hi = word_t'(k) << (8 + $urandom_range(1, 8));
        end
        else if (kind < 80)
        begin
            x  = $urandom();
            lo = $urandom();
            hi = $urandom_range(0, 1) ? lo : word_t'(longint'($urandom()) % (longint'(lo) + 1));
        end
        else
        begin
            x  = $urandom();
            lo = $urandom();
            hi = $urandom();
        end
    endtask

    task automatic run_random(input int unsigned count);
        word_t x;
        word_t lo;
        word_t hi;
        repeat (count)
        begin
            make_random_word(x, lo, hi);
            push_word(x, lo, hi);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed words at the reset tolerance of one.
        push_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_word(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        // midpoint of two all-ones bounds must not wrap
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // inverted brackets: no step, floor midpoint comes back
        push_word(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        push_word(32'h0001_0000, 32'h0003_0000, 32'h0001_0000);
        push_word(32'h0001_0000, 32'h0001_0001, 32'h0001_0000);
        // exact hits, first guess and after a few steps
        push_word(32'h0004_0000, 32'h0000_0000, 32'h0004_0000);
        push_word(32'h0004_0000, 32'h0000_0000, 32'h0010_0000);
        push_word(32'h0001_0000, 32'h0000_0000, 32'h0002_0000);
        // brackets that miss the root on either side, and one near the top of the range
        push_word(32'h0001_0000, 32'h0005_0000, 32'h0009_0000);
        push_word(32'h0064_0000, 32'h0000_0000, 32'h0001_0000);
        push_word(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        // plain convergence and narrow brackets
        push_word(32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        push_word(32'hFFFF_FFFF, 32'h00FF_0000, 32'h0101_0000);
        push_word(32'h0000_0001, 32'h0000_0000, 32'h0001_0000);
        push_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0001);
        push_word(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        push_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // Tolerance zero behaves as one.
        write_tolerance(tol_t'(0));
        run_random(120);
        write_tolerance(tol_t'(16'hFFFF));
        run_random(120);
        write_tolerance(tol_t'($urandom_range(2, 65534)));
        run_random(150);
        write_tolerance(tol_t'(1));
        run_random(140);

        drain_words();
        // Allow one full worst-case pass for a stray result to show up.
        repeat (3 * W + 8) @(posedge clk);

        $display("checked %0d roots from %0d words over five tolerance settings",
                 sb.roots_checked, sb.words_noted);
        $display("%0d exact roots, %0d flat or inverted brackets, %0d errors",
                 sb.exact_roots, sb.flat_brackets, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
